// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/vrt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_pkg
// types, codes and constants of the voxel ray traversal block
// ----------------------------------------------------------------------------
package vrt_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int VOXEL_BITS_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int NUM_W          = 64;
    localparam int SQ_W           = 64;
    localparam int OUT_VOX_W      = 16;

    localparam logic [TIME_W-1:0] TIME_NEVER   = '1;
    localparam logic [TIME_W-1:0] TIME_END_MAX = {{(TIME_W-1){1'b1}}, 1'b0};

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    typedef enum logic [1:0] {
        KIND_PROBE  = 2'd0,
        KIND_HIT    = 2'd1,
        KIND_MISS   = 2'd2,
        KIND_IGNORE = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV_NB,
        ST_DIV_CS,
        ST_ACC,
        ST_SQRT,
        ST_DIV_END,
        ST_ADV
    } state_t;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        max_distance;
        logic               is_solid;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                  kind;
        logic signed [OUT_VOX_W-1:0] voxel_x;
        logic signed [OUT_VOX_W-1:0] voxel_y;
        logic signed [OUT_VOX_W-1:0] voxel_z;
        logic [2:0]                  face;
    } out_item_t;

endpackage

// ===== hw/rtl/vrt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module vrt_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);
    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== hw/rtl/vrt_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrt_isqrt
// integer square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module vrt_isqrt #(
    parameter int W = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   n,
    output logic           done,
    output logic [W/2-1:0] root
);
    logic         busy_reg;
    logic         done_reg;
    logic [W-1:0] n_reg;
    logic [W-1:0] r_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] rb;
    logic         ge;

    always_comb
    begin
        rb = r_reg + b_reg;
        ge = n_reg >= rb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && b_reg[1:0] != 2'b00)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg <= n;
            r_reg <= '0;
            b_reg <= W'(1) << (W - 2);
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                n_reg <= n_reg - rb;
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
                r_reg <= r_reg >> 1;
            b_reg <= b_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = r_reg[W/2-1:0];

endmodule

// ===== hw/rtl/voxel_ray_traversal_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// voxel_ray_traversal_top
// grid walk along a ray: ray setup by a shared sequencer, one voxel per answer
// ----------------------------------------------------------------------------
//  channel | signals                      | direction | payload
//  in      | in_valid / in_ready          | into      | in_data  (in_item_t)
//  out     | out_valid / out_ready        | out of    | out_data (out_item_t)
//
//  an answer item gives its result in the cycle after acceptance
//  a start item runs, per axis, the setup step and, for a nonzero component, two
//  divisions, then the square root and the end-time division (skipped with an
//  all-zero direction) before the result load; the divider gives one quotient bit per cycle
//  reset clears all traversal state at once, no clearing pass
//  a stalled result holds in the output register; in_ready stays low meanwhile
//  only if the register cannot be emptied in the same cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module voxel_ray_traversal_top #(
    parameter int FRAC_BITS  = vrt_pkg::FRAC_BITS_DEF,
    parameter int VOXEL_BITS = vrt_pkg::VOXEL_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  vrt_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output vrt_pkg::out_item_t out_data
);
    import vrt_pkg::*;

    localparam int DEN_W = TIME_W;

    // sequencer
    state_t state_reg, state_next;

    // latched ray
    logic signed [31:0]  ori_reg [3];
    logic signed [31:0]  dir_reg [3];
    logic [30:0]         dist_reg;
    logic [1:0]          ax_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [SQ_W-1:0]     sumsq_reg;
    logic [SQ_W-1:0]     sumsq_next;

    // traversal state
    logic                  active_reg;
    logic [VOXEL_BITS-1:0] vox_reg [3];
    logic                  neg_reg [3];
    logic [TIME_W-1:0]     nb_reg [3];
    logic [TIME_W-1:0]     cs_reg [3];
    logic [TIME_W-1:0]     end_reg;
    logic [2:0]            face_reg;

    // output register
    logic      out_valid_reg;
    out_item_t out_data_reg;
    out_item_t out_next;

    // divider, shared by all divisions, and square root unit
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quo;
    logic             sqrt_start;
    logic             sqrt_done;
    logic [SQ_W/2-1:0] sqrt_root;

    // control strobes
    logic accept;
    logic out_free;
    logic out_load;
    logic adv_apply;

    // current axis during setup
    logic signed [31:0]    cur_o;
    logic signed [31:0]    cur_d;
    logic signed [31:0]    base_vox;
    logic [31:0]           mag;
    logic                  cur_neg;
    logic [FRAC_BITS-1:0]  frac;
    logic [FRAC_BITS:0]    gap;
    logic [TIME_W-1:0]     q_sat;
    logic [TIME_W-1:0]     q_end;

    // one step along the ray
    logic [1:0]            adv_a;
    logic [TIME_W-1:0]     adv_t;
    logic                  adv_past;
    logic [TIME_W:0]       adv_sum;
    logic [TIME_W-1:0]     adv_nb;
    logic [VOXEL_BITS-1:0] adv_vox;
    logic [VOXEL_BITS-1:0] adv_vox_all [3];
    logic [2:0]            adv_face;

    function automatic logic [OUT_VOX_W-1:0] vox_out(input logic [VOXEL_BITS-1:0] v);
        logic [31:0] ext;
        ext = {{(32 - VOXEL_BITS){v[VOXEL_BITS-1]}}, v};
        return ext[OUT_VOX_W-1:0];
    endfunction

    vrt_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    // root taken of the sum that includes the last axis
    vrt_isqrt #(
        .W (SQ_W)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .n     (sumsq_next),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // per-axis setup terms
    always_comb
    begin
        cur_o      = ori_reg[ax_reg];
        cur_d      = dir_reg[ax_reg];
        base_vox   = cur_o >>> FRAC_BITS;
        mag        = cur_d[31] ? (~cur_d + 32'd1) : cur_d;
        cur_neg    = cur_d[31] || (cur_d == 32'sd0);
        frac       = cur_o[FRAC_BITS-1:0];
        gap        = cur_neg ? {1'b0, frac}
                             : (((FRAC_BITS+1)'(1)) << FRAC_BITS) - {1'b0, frac};
        q_sat      = (|div_quo[NUM_W-1:TIME_W]) ? TIME_NEVER : div_quo[TIME_W-1:0];
        q_end      = (div_quo > NUM_W'(TIME_END_MAX)) ? TIME_END_MAX : div_quo[TIME_W-1:0];
        sumsq_next = sumsq_reg + sq_reg;
    end

    // least boundary time, x before y before z on ties
    always_comb
    begin
        if (nb_reg[0] <= nb_reg[1] && nb_reg[0] <= nb_reg[2])
            adv_a = 2'd0;
        else if (nb_reg[1] <= nb_reg[2])
            adv_a = 2'd1;
        else
            adv_a = 2'd2;
        adv_t    = nb_reg[adv_a];
        adv_past = adv_t > end_reg;
        adv_sum  = {1'b0, adv_t} + {1'b0, cs_reg[adv_a]};
        adv_nb   = adv_sum[TIME_W] ? TIME_NEVER : adv_sum[TIME_W-1:0];
        adv_vox  = neg_reg[adv_a] ? vox_reg[adv_a] - 1'b1 : vox_reg[adv_a] + 1'b1;
        adv_face = {adv_a, neg_reg[adv_a]};
        for (int i = 0; i < 3; i++)
            adv_vox_all[i] = (adv_a == 2'(i)) ? adv_vox : vox_reg[i];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (accept && in_data.operation == OP_START)
                    state_next = ST_SETUP;
            ST_SETUP:
                state_next = (mag == 32'd0) ? ST_ACC : ST_DIV_NB;
            ST_DIV_NB:
                if (div_done)
                    state_next = ST_DIV_CS;
            ST_DIV_CS:
                if (div_done)
                    state_next = ST_ACC;
            ST_ACC:
                state_next = (ax_reg == 2'd2) ? ST_SQRT : ST_SETUP;
            ST_SQRT:
                if (sqrt_done)
                    state_next = (sqrt_root == '0) ? ST_ADV : ST_DIV_END;
            ST_DIV_END:
                if (div_done)
                    state_next = ST_ADV;
            ST_ADV:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        out_free   = !out_valid_reg || out_ready;
        in_ready   = (state_reg == ST_IDLE) && out_free;
        accept     = in_valid && in_ready;
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = mag;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        adv_apply  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                out_load  = accept && in_data.operation == OP_ANSWER;
                adv_apply = out_load && active_reg && !in_data.is_solid;
            end
            ST_SETUP:
            begin
                div_start = mag != 32'd0;
                div_num   = NUM_W'(gap) << FRAC_BITS;
            end
            ST_DIV_NB:
            begin
                div_start = div_done;
                div_num   = NUM_W'(1) << (2 * FRAC_BITS);
            end
            ST_ACC:
                sqrt_start = ax_reg == 2'd2;
            ST_SQRT:
            begin
                div_start = sqrt_done && sqrt_root != '0;
                div_num   = NUM_W'(dist_reg) << FRAC_BITS;
                div_den   = sqrt_root;
            end
            ST_ADV:
            begin
                out_load  = out_free;
                adv_apply = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // result item
    always_comb
    begin
        out_next.kind    = KIND_MISS;
        out_next.voxel_x = '0;
        out_next.voxel_y = '0;
        out_next.voxel_z = '0;
        out_next.face    = '0;
        if (state_reg == ST_IDLE && !active_reg)
            out_next.kind = KIND_IGNORE;
        else if (state_reg == ST_IDLE && in_data.is_solid)
        begin
            out_next.kind    = KIND_HIT;
            out_next.voxel_x = vox_out(vox_reg[0]);
            out_next.voxel_y = vox_out(vox_reg[1]);
            out_next.voxel_z = vox_out(vox_reg[2]);
            out_next.face    = face_reg;
        end
        else if (!adv_past)
        begin
            out_next.kind    = KIND_PROBE;
            out_next.voxel_x = vox_out(adv_vox_all[0]);
            out_next.voxel_y = vox_out(adv_vox_all[1]);
            out_next.voxel_z = vox_out(adv_vox_all[2]);
            out_next.face    = adv_face;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            ax_reg        <= '0;
            active_reg    <= 1'b0;
            end_reg       <= '0;
            face_reg      <= '0;
            for (int i = 0; i < 3; i++)
            begin
                vox_reg[i] <= '0;
                neg_reg[i] <= 1'b0;
                nb_reg[i]  <= '0;
                cs_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && in_data.operation == OP_START)
                    begin
                        ax_reg   <= '0;
                        face_reg <= '0;
                    end
                    if (out_load && active_reg && in_data.is_solid)
                        active_reg <= 1'b0;
                end
                ST_SETUP:
                begin
                    vox_reg[ax_reg] <= base_vox[VOXEL_BITS-1:0];
                    neg_reg[ax_reg] <= cur_neg;
                    if (mag == 32'd0)
                    begin
                        nb_reg[ax_reg] <= TIME_NEVER;
                        cs_reg[ax_reg] <= TIME_NEVER;
                    end
                end
                ST_DIV_NB:
                    if (div_done)
                        nb_reg[ax_reg] <= q_sat;
                ST_DIV_CS:
                    if (div_done)
                        cs_reg[ax_reg] <= q_sat;
                ST_ACC:
                    if (ax_reg != 2'd2)
                        ax_reg <= ax_reg + 2'd1;
                ST_SQRT:
                    if (sqrt_done && sqrt_root == '0)
                        end_reg <= '0;
                ST_DIV_END:
                    if (div_done)
                        end_reg <= q_end;
                default:
                    ax_reg <= ax_reg;
            endcase

            // one step along the ray, or the end of it
            if (adv_apply)
            begin
                if (adv_past)
                    active_reg <= 1'b0;
                else
                begin
                    active_reg     <= 1'b1;
                    nb_reg[adv_a]  <= adv_nb;
                    vox_reg[adv_a] <= adv_vox;
                    face_reg       <= adv_face;
                end
            end
        end
    end

    // ray latch, setup datapath and result data register
    always_ff @(posedge clk)
    begin
        if (accept && in_data.operation == OP_START)
        begin
            ori_reg[0] <= in_data.origin_x;
            ori_reg[1] <= in_data.origin_y;
            ori_reg[2] <= in_data.origin_z;
            dir_reg[0] <= in_data.dir_x;
            dir_reg[1] <= in_data.dir_y;
            dir_reg[2] <= in_data.dir_z;
            dist_reg   <= in_data.max_distance;
            sumsq_reg  <= '0;
        end
        if (state_reg == ST_SETUP)
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        if (state_reg == ST_ACC)
            sumsq_reg <= sumsq_next;
        if (out_load)
            out_data_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_IMPL(a_ready_only_idle, in_ready, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_axis_in_range, state_reg != ST_IDLE, ax_reg != 2'd3)
    `ASSERT_IMPL(a_end_not_never, active_reg, end_reg != TIME_NEVER)
    `ASSERT_NEXT(a_start_leaves_idle, accept && in_data.operation == OP_START,
                 state_reg == ST_SETUP && !in_ready)

endmodule
